// File: hw/rtl/rower_quadrature_stroke_timer_defines.svh
// Assertion macros used by the stroke timer control module.
`ifndef ROWER_QUADRATURE_STROKE_TIMER_DEFINES_SVH
`define ROWER_QUADRATURE_STROKE_TIMER_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define RQST_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define RQST_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/rqst_pkg.sv
// Types and constants shared by the stroke timer modules.
package rqst_pkg;

  // Beat widths on the stream channels
  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 176;
  localparam int M_USER_W = 2;

  // Configuration register indexes
  localparam logic [1:0] REG_DEBOUNCE     = 2'd0;
  localparam logic [1:0] REG_MIN_INTERVAL = 2'd1;
  localparam logic [1:0] REG_IDLE_TIMEOUT = 2'd2;

  // Configuration reset values
  localparam logic [31:0] DEF_DEBOUNCE     = 32'd20000;
  localparam logic [31:0] DEF_MIN_INTERVAL = 32'd2500;
  localparam logic [31:0] DEF_IDLE_TIMEOUT = 32'd1000000;

  // Ten times strokes per minute: dividend in microseconds
  localparam int SPM_NUM_W = 30;
  localparam logic [SPM_NUM_W-1:0] SPM_NUM = 30'd600000000;
  // Stroke times at or below this give a quotient above 16 bits
  localparam logic [31:0] SPM_SAT_LIMIT = 32'd9155;
  localparam logic [15:0] SPM_SAT = 16'hFFFF;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_CLASS,
    S_DIV,
    S_COMMIT
  } rqst_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic eval;
    logic div_start;
    logic commit;
  } rqst_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic no_report;
    logic short_pull;
    logic stroke_begin;
    logic div_done;
    logic out_free;
  } rqst_sts_t;

endpackage

// File: hw/rtl/rqst_div.sv
// Iterative restoring divider: fixed dividend over a 30-bit stroke time.
module rqst_div
  import rqst_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [SPM_NUM_W-1:0] divisor,
  output logic                 done,
  output logic [15:0]          quotient
);

  logic                 busy;
  logic [4:0]           cnt;
  logic [SPM_NUM_W:0]   rem;
  logic [SPM_NUM_W-1:0] dvs;
  logic [SPM_NUM_W:0]   rem_shift;
  logic                 take;

  // Shift in the next dividend bit and try a subtract
  assign rem_shift = {rem[SPM_NUM_W-1:0], SPM_NUM[cnt]};
  assign take      = rem_shift >= {1'b0, dvs};

  // Control: count one quotient bit per cycle, MSB first
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 5'd0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(SPM_NUM_W - 1);
      end else if (busy) begin
        if (cnt == 5'd0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end

  // Datapath: remainder and low quotient bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      rem      <= take ? (rem_shift - {1'b0, dvs}) : rem_shift;
      quotient <= {quotient[14:0], take};
    end
  end

endmodule

// File: hw/rtl/rqst_ctrl.sv
// Sequencing state machine of the stroke timer.
`include "rower_quadrature_stroke_timer_defines.svh"

module rqst_ctrl
  import rqst_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  rqst_sts_t sts,
  output rqst_cmd_t cmd
);

  rqst_state_t state, state_next;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_EVAL;
      end
      S_EVAL: begin
        state_next = S_CLASS;
      end
      S_CLASS: begin
        if (sts.no_report || sts.short_pull) state_next = S_IDLE;
        else if (sts.stroke_begin)           state_next = S_DIV;
        else                                 state_next = S_COMMIT;
      end
      S_DIV: begin
        if (sts.div_done) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    s_tready      = 1'b0;
    cmd           = '0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
      end
      S_CLASS: begin
        cmd.div_start = !sts.no_report && !sts.short_pull && sts.stroke_begin;
      end
      S_COMMIT: begin
        cmd.commit = sts.out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  `RQST_ASSERT_IMPL(a_commit_free, cmd.commit, sts.out_free, "commit with output register full")
  `RQST_ASSERT_IMPL(a_div_cause, cmd.div_start, sts.stroke_begin && !sts.no_report, "divide without stroke start")
  `RQST_ASSERT_NEXT(a_load_eval, cmd.load, state == S_EVAL, "accepted beat not evaluated")

endmodule

// File: hw/rtl/rqst_dp.sv
// Datapath: edge tracking, interval, stroke state, config and output register.
module rqst_dp
  import rqst_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                sensor_a,
  input  logic                sensor_b,
  input  logic [31:0]         now_usec,
  input  rqst_cmd_t           cmd,
  output rqst_sts_t           sts,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,
  output logic [M_USER_W-1:0] m_tuser
);

  localparam int SW = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam logic signed [SW-1:0] SMAX = SW'(64'sh7FFFFFFF);
  localparam logic signed [SW-1:0] SMIN = SW'(-64'sh80000000);

  // Signed time difference saturated to 32 bits
  function automatic logic [31:0] sdiff(input logic [TIME_BITS-1:0] x,
                                        input logic [TIME_BITS-1:0] y);
    logic [TIME_BITS-1:0] d;
    logic signed [SW-1:0] dx;
    d  = x - y;
    dx = SW'(signed'(d));
    if (dx > SMAX)      sdiff = 32'h7FFFFFFF;
    else if (dx < SMIN) sdiff = 32'h80000000;
    else                sdiff = dx[31:0];
  endfunction

  function automatic logic spos(input logic [31:0] v);
    spos = (v != 32'd0) && !v[31];
  endfunction

  // Configuration registers
  logic [31:0] debounce_usec, min_interval_usec, idle_timeout_usec;

  // Latched input beat
  logic                 in_a, in_b;
  logic [TIME_BITS-1:0] in_now;

  // Edge tracking state
  logic                 prev_a, prev_b, armed;
  logic [TIME_BITS-1:0] fall_time_a, rise_time_a, fall_time_b, rise_time_b;

  // Per-beat results of evaluation
  logic                 got;
  logic                 idle_hit;
  logic [31:0]          cand;
  logic [TIME_BITS-1:0] sd;
  logic                 spm_sat, spm_zero;

  // Stroke state
  logic [31:0]          prev_interval;
  logic [TIME_BITS-1:0] last_report_time, stroke_start_time, return_time;
  logic [15:0]          spm_value, tick_in_stroke, tick_last_stroke;
  logic [31:0]          return_count;
  logic                 pulling;

  // Edge evaluation signals
  logic [TIME_BITS-1:0] age_a, age_b, idle_age;
  logic                 armed_next, got_next;
  logic [31:0]          iv_next;
  logic [TIME_BITS-1:0] fa_next, ra_next, fb_next, rb_next;

  // Divider
  logic        div_done;
  logic [15:0] div_q;

  // Commit values
  logic                 pos;
  logic [15:0]          spm_next, tick_in_next, tick_last_next;
  logic [31:0]          return_count_next;
  logic [TIME_BITS-1:0] return_time_next, stroke_start_next;
  logic                 pulling_next;
  logic [31:0]          since_next;

  // Output register fields
  logic [31:0] out_interval, out_total, out_total_time, out_since;
  logic [15:0] out_spm, out_this, out_prev;
  logic        out_timeout, out_start;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_usec     <= DEF_DEBOUNCE;
      min_interval_usec <= DEF_MIN_INTERVAL;
      idle_timeout_usec <= DEF_IDLE_TIMEOUT;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEBOUNCE:     debounce_usec     <= cfg_data;
        REG_MIN_INTERVAL: min_interval_usec <= cfg_data;
        REG_IDLE_TIMEOUT: idle_timeout_usec <= cfg_data;
        default:          debounce_usec     <= debounce_usec;
      endcase
    end
  end

  // Latch the accepted beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_a   <= sensor_a;
      in_b   <= sensor_b;
      in_now <= TIME_BITS'(now_usec);
    end
  end

  assign age_a    = in_now - rise_time_a;
  assign age_b    = in_now - rise_time_b;
  assign idle_age = in_now - last_report_time;

  // Falling and rising edges, debounce and the armed interval; A is examined before B
  always_comb begin
    armed_next = armed || (in_a && in_b);
    got_next   = 1'b0;
    iv_next    = 32'd0;
    fa_next    = fall_time_a;
    ra_next    = rise_time_a;
    fb_next    = fall_time_b;
    rb_next    = rise_time_b;
    if (!in_a && prev_a) begin
      if (SW'(age_a) > SW'(debounce_usec)) fa_next = in_now;
      if (!in_b && armed_next) begin
        armed_next = 1'b0;
        got_next   = 1'b1;
        iv_next    = sdiff(fall_time_b, in_now);
      end
    end
    if (in_a && !prev_a) ra_next = in_now;
    if (!in_b && prev_b) begin
      if (SW'(age_b) > SW'(debounce_usec)) fb_next = in_now;
      if (!in_a && armed_next) begin
        armed_next = 1'b0;
        got_next   = 1'b1;
        iv_next    = sdiff(in_now, fa_next);
      end
    end
    if (in_b && !prev_b) rb_next = in_now;
  end

  // Commit edge state and register the evaluation
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_a      <= 1'b0;
      prev_b      <= 1'b0;
      armed       <= 1'b0;
      fall_time_a <= '0;
      rise_time_a <= '0;
      fall_time_b <= '0;
      rise_time_b <= '0;
    end else if (cmd.eval) begin
      prev_a      <= in_a;
      prev_b      <= in_b;
      armed       <= armed_next;
      fall_time_a <= fa_next;
      rise_time_a <= ra_next;
      fall_time_b <= fb_next;
      rise_time_b <= rb_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      got      <= got_next;
      idle_hit <= SW'(idle_age) >= SW'(idle_timeout_usec);
      cand     <= iv_next;
      sd       <= in_now - stroke_start_time;
    end
  end

  // Classify the beat
  assign pos              = spos(cand);
  assign sts.no_report    = !got && !idle_hit;
  assign sts.short_pull   = pos && (cand < min_interval_usec);
  assign sts.stroke_begin = pos && !spos(prev_interval);
  assign sts.div_done     = div_done;
  assign sts.out_free     = !m_tvalid || m_tready;

  // Stroke time range checks for the rate
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      spm_sat  <= SW'(sd) <= SW'(SPM_SAT_LIMIT);
      spm_zero <= SW'(sd) > SW'(SPM_NUM);
    end
  end

  rqst_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .divisor  (SPM_NUM_W'(sd)),
    .done     (div_done),
    .quotient (div_q)
  );

  // Next stroke state for a reported beat
  always_comb begin
    spm_next          = spm_value;
    tick_in_next      = tick_in_stroke;
    tick_last_next    = tick_last_stroke;
    return_count_next = return_count;
    return_time_next  = return_time;
    stroke_start_next = stroke_start_time;
    pulling_next      = pulling;
    since_next        = 32'(sd);
    if (pos) begin
      if (sts.stroke_begin) begin
        if (spm_sat)       spm_next = SPM_SAT;
        else if (spm_zero) spm_next = 16'd0;
        else               spm_next = div_q;
        stroke_start_next = in_now;
        tick_last_next    = tick_in_stroke;
        tick_in_next      = 16'd1;
        since_next        = 32'd0;
      end else if (tick_in_stroke != 16'hFFFF) begin
        tick_in_next = tick_in_stroke + 16'd1;
      end
      pulling_next = 1'b1;
    end else begin
      if (pulling) begin
        return_time_next  = in_now;
        return_count_next = return_count + 32'd1;
      end
      pulling_next = 1'b0;
      if (!got) spm_next = 16'd0;
    end
  end

  // Commit stroke state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_interval     <= '0;
      last_report_time  <= '0;
      stroke_start_time <= '0;
      return_time       <= '0;
      spm_value         <= '0;
      tick_in_stroke    <= '0;
      tick_last_stroke  <= '0;
      return_count      <= '0;
      pulling           <= 1'b0;
    end else if (cmd.commit) begin
      prev_interval     <= cand;
      last_report_time  <= in_now;
      stroke_start_time <= stroke_start_next;
      return_time       <= return_time_next;
      spm_value         <= spm_next;
      tick_in_stroke    <= tick_in_next;
      tick_last_stroke  <= tick_last_next;
      return_count      <= return_count_next;
      pulling           <= pulling_next;
    end
  end

  // Output register: load on commit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_interval   <= cand;
      out_timeout    <= !got;
      out_start      <= sts.stroke_begin;
      out_spm        <= spm_next;
      out_this       <= tick_in_next;
      out_prev       <= tick_last_next;
      out_total      <= return_count_next;
      out_total_time <= 32'(return_time_next);
      out_since      <= since_next;
    end
  end

  assign m_tdata = {out_since, out_total_time, out_total, out_prev, out_this, out_spm,
                    out_interval};
  assign m_tuser = {out_start, out_timeout};

endmodule

// File: hw/rtl/rower_quadrature_stroke_timer.sv
// Top level of the rower quadrature stroke timer.
//
// Input stream (s_*): one beat per sample of the two active-low magnet
// sensors and its microsecond time stamp. Output stream (m_*): at most one
// result beat per input beat, carrying the edge interval and stroke data.
// Configuration (cfg_*): writes debounce, minimum interval and idle
// timeout registers; cfg_ready is always high. Writes must be made while
// idle; the block does not enforce this. A sample that yields no result
// goes from classify back to idle. A result without a new stroke goes
// from classify to commit and is registered on m_*. A result that starts
// a stroke first runs the bit-serial strokes-per-minute divider over the
// 30 dividend bits. No new sample is taken until the last is through. A
// finished result waits in the output register while the next sample is
// taken; if m_tready stays low, the following result holds in the
// datapath and s_tready stays low until the register frees.
// Reset clears all edge and stroke state, loads register defaults and
// empties the output register.
module rower_quadrature_stroke_timer
  import rqst_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // sensor_a [0], sensor_b [1], now_usec [33:2], zero [39:34]
  input  logic [S_DATA_W-1:0] s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // interval_usec [31:0], spm_x10 [47:32], ticks_this_stroke [63:48],
  // ticks_prev_stroke [79:64], stroke_total [111:80],
  // stroke_total_time [143:112], since_stroke_usec [175:144]
  output logic [M_DATA_W-1:0] m_tdata,
  // is_timeout [0], stroke_start [1]
  output logic [M_USER_W-1:0] m_tuser,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  rqst_cmd_t cmd;
  rqst_sts_t sts;

  assign cfg_ready = 1'b1;

  rqst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rqst_dp #(
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sensor_a  (s_tdata[0]),
    .sensor_b  (s_tdata[1]),
    .now_usec  (s_tdata[33:2]),
    .cmd       (cmd),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
